[sv/nsq_pkg.sv]
package nsq_pkg;

    // Field widths
    localparam int INSET_W    = 12;
    localparam int ATLAS_W    = 13;
    localparam int POS_W      = 12;
    localparam int SIZE_W     = 13;
    localparam int CELL_W     = 4;
    localparam int DST_W      = 14;
    localparam int TEX_W      = 19;
    localparam int TEXEL_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int FRAC_BITS_DEF = 16;

    // Four breakpoints per axis, horizontal ones first
    localparam int NUM_BP_AXIS = 4;
    localparam int NUM_BP      = 2 * NUM_BP_AXIS;
    localparam int BP_IDX_W    = $clog2(NUM_BP);
    localparam int GRID        = 3;
    localparam int NUM_CELLS   = GRID * GRID;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INSET_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INSET_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INSET_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INSET_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 3'd5;

    localparam logic [TEX_W-1:0] TEX_POS_MAX = {1'b0, {(TEX_W-1){1'b1}}};
    localparam logic [TEX_W-1:0] TEX_NEG_MAX = {1'b1, {(TEX_W-1){1'b0}}};

    typedef logic signed [DST_W-1:0]   t_dst;
    typedef logic signed [TEXEL_W-1:0] t_texel;
    typedef logic signed [TEX_W-1:0]   t_tex;
    typedef logic [BP_IDX_W-1:0]       t_bp_idx;

    typedef struct packed {
        logic [INSET_W-1:0] inset_left;
        logic [INSET_W-1:0] inset_right;
        logic [INSET_W-1:0] inset_top;
        logic [INSET_W-1:0] inset_bottom;
        logic [ATLAS_W-1:0] div_w;
        logic [ATLAS_W-1:0] div_h;
    } t_cfg;

    // One classified request: destination and source breakpoints
    typedef struct packed {
        t_dst   [NUM_BP-1:0] side;
        t_texel [NUM_BP-1:0] tex;
    } t_job;

    typedef struct packed {
        t_bp_idx idx;
        t_dst    side;
        t_texel  texel;
    } t_div_elem;

    typedef struct packed {
        t_bp_idx idx;
        t_dst    side;
        t_tex    quot;
    } t_div_res;

    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic              last;
        t_dst              dst_x0;
        t_dst              dst_y0;
        t_dst              dst_x1;
        t_dst              dst_y1;
        t_tex              tex_u0;
        t_tex              tex_v0;
        t_tex              tex_u1;
        t_tex              tex_v1;
    } t_quad;

    // A zero atlas size divides as one
    function automatic logic [ATLAS_W-1:0] eff_div(input logic [ATLAS_W-1:0] size);
        eff_div = (size == '0) ? ATLAS_W'(1) : size;
    endfunction

endpackage

[sv/nsq_queue.sv]
module nsq_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nsq_pkg::t_job i_wdata,
    input  logic          i_pop,
    output logic          o_valid,
    output nsq_pkg::t_job o_rdata,
    output logic          o_full
);
    import nsq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

[sv/nsq_front.sv]
module nsq_front (
    input  logic                        i_in_valid,
    input  logic [nsq_pkg::POS_W-1:0]   i_rect_left,
    input  logic [nsq_pkg::POS_W-1:0]   i_rect_top,
    input  logic [nsq_pkg::SIZE_W-1:0]  i_rect_width,
    input  logic [nsq_pkg::SIZE_W-1:0]  i_rect_height,
    input  logic [nsq_pkg::SIZE_W-1:0]  i_out_width,
    input  logic [nsq_pkg::SIZE_W-1:0]  i_out_height,
    input  nsq_pkg::t_cfg               i_cfg,
    input  logic                        i_q_full,
    output logic                        o_in_ready,
    output logic                        o_push,
    output nsq_pkg::t_job               o_job
);
    import nsq_pkg::*;

    logic [TEXEL_W-1:0] w_rl;
    logic [TEXEL_W-1:0] w_rt;
    logic [TEXEL_W-1:0] w_rl_rw;
    logic [TEXEL_W-1:0] w_rt_rh;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign w_rl    = TEXEL_W'(i_rect_left);
    assign w_rt    = TEXEL_W'(i_rect_top);
    assign w_rl_rw = w_rl + TEXEL_W'(i_rect_width);
    assign w_rt_rh = w_rt + TEXEL_W'(i_rect_height);

    // Breakpoints 0..3 are horizontal, 4..7 vertical. Differences wrap in
    // their width, which holds a negative middle breakpoint exactly.
    always_comb begin
        o_job.side[0] = '0;
        o_job.side[1] = DST_W'(i_cfg.inset_left);
        o_job.side[2] = DST_W'(i_out_width) - DST_W'(i_cfg.inset_right);
        o_job.side[3] = DST_W'(i_out_width);
        o_job.side[4] = '0;
        o_job.side[5] = DST_W'(i_cfg.inset_top);
        o_job.side[6] = DST_W'(i_out_height) - DST_W'(i_cfg.inset_bottom);
        o_job.side[7] = DST_W'(i_out_height);

        o_job.tex[0] = w_rl;
        o_job.tex[1] = w_rl + TEXEL_W'(i_cfg.inset_left);
        o_job.tex[2] = w_rl_rw - TEXEL_W'(i_cfg.inset_right);
        o_job.tex[3] = w_rl_rw;
        o_job.tex[4] = w_rt;
        o_job.tex[5] = w_rt + TEXEL_W'(i_cfg.inset_top);
        o_job.tex[6] = w_rt_rh - TEXEL_W'(i_cfg.inset_bottom);
        o_job.tex[7] = w_rt_rh;
    end

endmodule

[sv/nsq_divider.sv]
module nsq_divider #(
    parameter int FRAC_BITS = nsq_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  nsq_pkg::t_div_elem           i_elem,
    input  logic [nsq_pkg::ATLAS_W-1:0]  i_div_w,
    input  logic [nsq_pkg::ATLAS_W-1:0]  i_div_h,
    output logic                         o_valid,
    output nsq_pkg::t_div_res            o_res
);
    import nsq_pkg::*;

    localparam int NW     = TEXEL_W + FRAC_BITS;
    localparam int HIW    = NW - TEX_W;
    localparam int CW     = (HIW > ATLAS_W) ? HIW : ATLAS_W;
    localparam int STAGES = TEX_W;

    // Stage 0 checks for overflow and loads the partial remainder; each
    // later stage retires one quotient bit.
    logic               r_vld [0:STAGES];
    logic               r_neg [0:STAGES];
    logic               r_sat [0:STAGES];
    t_bp_idx            r_idx [0:STAGES];
    t_dst               r_side[0:STAGES];
    logic [ATLAS_W-1:0] r_rem [0:STAGES];
    logic [TEX_W-1:0]   r_low [0:STAGES];
    logic [TEX_W-1:0]   r_quo [0:STAGES];

    logic               n_vld [0:STAGES];
    logic               n_neg [0:STAGES];
    logic               n_sat [0:STAGES];
    t_bp_idx            n_idx [0:STAGES];
    t_dst               n_side[0:STAGES];
    logic [ATLAS_W-1:0] n_rem [0:STAGES];
    logic [TEX_W-1:0]   n_low [0:STAGES];
    logic [TEX_W-1:0]   n_quo [0:STAGES];

    logic [TEXEL_W-1:0] w_t;
    logic [TEXEL_W-1:0] w_mag;
    logic [NW-1:0]      w_num;
    logic [HIW-1:0]     w_hi;
    logic [ATLAS_W-1:0] w_d0;
    logic [ATLAS_W-1:0] w_dk [1:STAGES];
    logic [ATLAS_W:0]   w_ext[1:STAGES];
    logic [ATLAS_W:0]   w_sub[1:STAGES];
    logic               w_ge [1:STAGES];
    logic [TEX_W-1:0]   w_mq;

    assign w_t   = i_elem.texel;
    assign w_mag = w_t[TEXEL_W-1] ? (~w_t + 1'b1) : w_t;
    assign w_num = {w_mag, {FRAC_BITS{1'b0}}};
    assign w_hi  = w_num[NW-1:TEX_W];
    assign w_d0  = i_elem.idx[BP_IDX_W-1] ? i_div_h : i_div_w;

    always_comb begin
        n_vld[0]  = i_valid;
        n_neg[0]  = w_t[TEXEL_W-1];
        n_sat[0]  = (CW'(w_hi) >= CW'(w_d0));
        n_idx[0]  = i_elem.idx;
        n_side[0] = i_elem.side;
        n_rem[0]  = ATLAS_W'(w_hi);
        n_low[0]  = w_num[TEX_W-1:0];
        n_quo[0]  = '0;
        for (int k = 1; k <= STAGES; k++) begin
            w_dk[k]   = r_idx[k-1][BP_IDX_W-1] ? i_div_h : i_div_w;
            w_ext[k]  = {r_rem[k-1], r_low[k-1][TEX_W-1]};
            w_sub[k]  = w_ext[k] - {1'b0, w_dk[k]};
            w_ge[k]   = (w_ext[k] >= {1'b0, w_dk[k]});
            n_vld[k]  = r_vld[k-1];
            n_neg[k]  = r_neg[k-1];
            n_sat[k]  = r_sat[k-1];
            n_idx[k]  = r_idx[k-1];
            n_side[k] = r_side[k-1];
            n_rem[k]  = w_ge[k] ? w_sub[k][ATLAS_W-1:0] : w_ext[k][ATLAS_W-1:0];
            n_low[k]  = {r_low[k-1][TEX_W-2:0], 1'b0};
            n_quo[k]  = {r_quo[k-1][TEX_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_neg[k]  <= n_neg[k];
                r_sat[k]  <= n_sat[k];
                r_idx[k]  <= n_idx[k];
                r_side[k] <= n_side[k];
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_quo[k]  <= n_quo[k];
            end
        end
    end

    // Apply the sign and clamp to the coordinate range.
    assign w_mq = r_quo[STAGES];

    always_comb begin
        o_res.idx  = r_idx[STAGES];
        o_res.side = r_side[STAGES];
        if (!r_neg[STAGES]) begin
            o_res.quot = (r_sat[STAGES] || w_mq[TEX_W-1]) ? TEX_POS_MAX : w_mq;
        end else begin
            o_res.quot = (r_sat[STAGES] || (w_mq > TEX_NEG_MAX)) ? TEX_NEG_MAX
                                                                 : (~w_mq + 1'b1);
        end
    end

    assign o_valid = r_vld[STAGES];

endmodule

[sv/nsq_back.sv]
module nsq_back #(
    parameter int FRAC_BITS = nsq_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  nsq_pkg::t_job                i_q_data,
    output logic                         o_q_pop,
    input  logic [nsq_pkg::ATLAS_W-1:0]  i_div_w,
    input  logic [nsq_pkg::ATLAS_W-1:0]  i_div_h,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output nsq_pkg::t_quad               o_quad
);
    import nsq_pkg::*;

    localparam t_bp_idx           BP_LAST   = t_bp_idx'(NUM_BP - 1);
    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(NUM_CELLS - 1);
    localparam logic [1:0]        GX_LAST   = 2'(GRID - 1);

    logic              w_en;
    logic              w_issue;
    t_div_elem         w_elem;
    logic              w_res_valid;
    t_div_res          w_res;
    logic              w_coll_wr;
    logic              w_emit_adv;
    logic              w_emit_done;
    logic              w_xfer;

    t_bp_idx           r_iss;
    logic              r_coll_full;
    t_tex              r_cq [NUM_BP];
    t_dst              r_cs [NUM_BP];

    logic              r_ebusy;
    logic [CELL_W-1:0] r_cell;
    logic [1:0]        r_gx;
    t_tex              r_eu [NUM_BP_AXIS];
    t_tex              r_ev [NUM_BP_AXIS];
    t_dst              r_ex [NUM_BP_AXIS];
    t_dst              r_ey [NUM_BP_AXIS];

    // The whole pipeline holds while a result waits on a full collector.
    assign w_en    = !(w_res_valid && r_coll_full);
    assign w_issue = i_q_valid && w_en;
    assign o_q_pop = w_issue && (r_iss == BP_LAST);

    assign w_elem.idx   = r_iss;
    assign w_elem.side  = i_q_data.side[r_iss];
    assign w_elem.texel = i_q_data.tex[r_iss];

    nsq_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_q_valid),
        .i_elem  (w_elem),
        .i_div_w (i_div_w),
        .i_div_h (i_div_h),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    assign w_coll_wr   = w_res_valid && !r_coll_full;
    assign w_emit_adv  = r_ebusy && i_out_ready && (r_cell != CELL_LAST);
    assign w_emit_done = r_ebusy && i_out_ready && (r_cell == CELL_LAST);
    assign w_xfer      = r_coll_full && (!r_ebusy || w_emit_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss       <= '0;
            r_coll_full <= 1'b0;
            r_ebusy     <= 1'b0;
            r_cell      <= '0;
            r_gx        <= '0;
        end else begin
            if (w_issue) begin
                r_iss <= (r_iss == BP_LAST) ? '0 : r_iss + 1'b1;
            end
            if (w_coll_wr && (w_res.idx == BP_LAST)) begin
                r_coll_full <= 1'b1;
            end else if (w_xfer) begin
                r_coll_full <= 1'b0;
            end
            if (w_xfer) begin
                r_ebusy <= 1'b1;
                r_cell  <= '0;
                r_gx    <= '0;
            end else if (w_emit_done) begin
                r_ebusy <= 1'b0;
            end else if (w_emit_adv) begin
                r_cell <= r_cell + 1'b1;
                r_gx   <= (r_gx == GX_LAST) ? '0 : r_gx + 1'b1;
            end
        end
    end

    // Breakpoint pairs are kept in rotating rows so each quad reads the
    // first two entries of each row.
    always_ff @(posedge i_clk) begin
        if (w_coll_wr) begin
            r_cq[w_res.idx] <= w_res.quot;
            r_cs[w_res.idx] <= w_res.side;
        end
        if (w_xfer) begin
            for (int i = 0; i < NUM_BP_AXIS; i++) begin
                r_eu[i] <= r_cq[i];
                r_ex[i] <= r_cs[i];
                r_ev[i] <= r_cq[NUM_BP_AXIS + i];
                r_ey[i] <= r_cs[NUM_BP_AXIS + i];
            end
        end else if (w_emit_adv) begin
            if (r_gx == GX_LAST) begin
                for (int i = 0; i < NUM_BP_AXIS; i++) begin
                    r_eu[i] <= r_eu[(i + 2) % NUM_BP_AXIS];
                    r_ex[i] <= r_ex[(i + 2) % NUM_BP_AXIS];
                    r_ev[i] <= r_ev[(i + 1) % NUM_BP_AXIS];
                    r_ey[i] <= r_ey[(i + 1) % NUM_BP_AXIS];
                end
            end else begin
                for (int i = 0; i < NUM_BP_AXIS; i++) begin
                    r_eu[i] <= r_eu[(i + 1) % NUM_BP_AXIS];
                    r_ex[i] <= r_ex[(i + 1) % NUM_BP_AXIS];
                end
            end
        end
    end

    assign o_out_valid       = r_ebusy;
    assign o_quad.cell_index = r_cell;
    assign o_quad.last       = (r_cell == CELL_LAST);
    assign o_quad.dst_x0     = r_ex[0];
    assign o_quad.dst_x1     = r_ex[1];
    assign o_quad.dst_y0     = r_ey[0];
    assign o_quad.dst_y1     = r_ey[1];
    assign o_quad.tex_u0     = r_eu[0];
    assign o_quad.tex_u1     = r_eu[1];
    assign o_quad.tex_v0     = r_ev[0];
    assign o_quad.tex_v1     = r_ev[1];

endmodule

[sv/nine_slice_quad_generator_unit.sv]
// An accepted request passes through the job queue, the divider and the collector
// to the emitter, which gives one quad a cycle while the consumer is ready; nine
// quads per request. The pipelined divider takes one of the eight quotients of a
// request each cycle while no result waits on a full collector.
// Reset: synchronous, active low; clears the queue, divider valid bits and
// emitter, and returns the registers to insets 0 and atlas sizes 1.
module nine_slice_quad_generator_unit #(
    parameter int FRAC_BITS = nsq_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [nsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nsq_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [nsq_pkg::POS_W-1:0]       i_rect_left,
    input  logic [nsq_pkg::POS_W-1:0]       i_rect_top,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_rect_width,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_rect_height,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_out_width,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_out_height,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [nsq_pkg::CELL_W-1:0]      o_cell_index,
    output logic                            o_last,
    output logic signed [nsq_pkg::DST_W-1:0] o_dst_x0,
    output logic signed [nsq_pkg::DST_W-1:0] o_dst_y0,
    output logic signed [nsq_pkg::DST_W-1:0] o_dst_x1,
    output logic signed [nsq_pkg::DST_W-1:0] o_dst_y1,
    output logic signed [nsq_pkg::TEX_W-1:0] o_tex_u0,
    output logic signed [nsq_pkg::TEX_W-1:0] o_tex_v0,
    output logic signed [nsq_pkg::TEX_W-1:0] o_tex_u1,
    output logic signed [nsq_pkg::TEX_W-1:0] o_tex_v1
);
    import nsq_pkg::*;

    // Configuration registers. The user must write them only while the block is idle,
    // which the block does not enforce; the pipeline reads them directly without any shadow copy.
    logic [INSET_W-1:0] r_inset_left;
    logic [INSET_W-1:0] r_inset_right;
    logic [INSET_W-1:0] r_inset_top;
    logic [INSET_W-1:0] r_inset_bottom;
    logic [ATLAS_W-1:0] r_atlas_width;
    logic [ATLAS_W-1:0] r_atlas_height;

    t_cfg  w_cfg;
    logic  w_push;
    t_job  w_job;
    logic  w_q_full;
    logic  w_q_valid;
    t_job  w_q_data;
    logic  w_q_pop;
    t_quad w_quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inset_left   <= '0;
            r_inset_right  <= '0;
            r_inset_top    <= '0;
            r_inset_bottom <= '0;
            r_atlas_width  <= ATLAS_W'(1);
            r_atlas_height <= ATLAS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INSET_LEFT:   r_inset_left   <= i_cfg_data[INSET_W-1:0];
                REG_INSET_RIGHT:  r_inset_right  <= i_cfg_data[INSET_W-1:0];
                REG_INSET_TOP:    r_inset_top    <= i_cfg_data[INSET_W-1:0];
                REG_INSET_BOTTOM: r_inset_bottom <= i_cfg_data[INSET_W-1:0];
                REG_ATLAS_WIDTH:  r_atlas_width  <= i_cfg_data[ATLAS_W-1:0];
                REG_ATLAS_HEIGHT: r_atlas_height <= i_cfg_data[ATLAS_W-1:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // A zero atlas size is treated as one before it reaches the divider.
    assign w_cfg.inset_left   = r_inset_left;
    assign w_cfg.inset_right  = r_inset_right;
    assign w_cfg.inset_top    = r_inset_top;
    assign w_cfg.inset_bottom = r_inset_bottom;
    assign w_cfg.div_w        = eff_div(r_atlas_width);
    assign w_cfg.div_h        = eff_div(r_atlas_height);

    // Front end: turns each request item into its eight breakpoints and
    // places them in the job queue.
    nsq_front u_front (
        .i_in_valid    (i_in_valid),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_out_width   (i_out_width),
        .i_out_height  (i_out_height),
        .i_cfg         (w_cfg),
        .i_q_full      (w_q_full),
        .o_in_ready    (o_in_ready),
        .o_push        (w_push),
        .o_job         (w_job)
    );

    // Two-entry job queue, so a new request is taken while the back end is
    // still busy with earlier ones.
    nsq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_job),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_rdata (w_q_data),
        .o_full  (w_q_full)
    );

    // Back end: issues the eight normalisations of a job into the pipelined
    // divider, gathers the quotients and emits the nine quads in row order.
    // The collector fills for the next job while the emitter drains the
    // current one, so a stalled consumer backs up through the divider and the queue into the input.
    nsq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_q_pop     (w_q_pop),
        .i_div_w     (w_cfg.div_w),
        .i_div_h     (w_cfg.div_h),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_quad      (w_quad)
    );

    assign o_cell_index = w_quad.cell_index;
    assign o_last       = w_quad.last;
    assign o_dst_x0     = w_quad.dst_x0;
    assign o_dst_y0     = w_quad.dst_y0;
    assign o_dst_x1     = w_quad.dst_x1;
    assign o_dst_y1     = w_quad.dst_y1;
    assign o_tex_u0     = w_quad.tex_u0;
    assign o_tex_v0     = w_quad.tex_v0;
    assign o_tex_u1     = w_quad.tex_u1;
    assign o_tex_v1     = w_quad.tex_v1;

`ifndef SYNTHESIS
    // Reset leaves no quad on offer.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("quad offered straight after reset");

    // Within a request the quads follow one another without a gap.
    a_cell_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
        (o_out_valid && (o_cell_index == $past(o_cell_index) + 4'd1)))
        else $error("quad sequence broken inside a request");

    // Neighbouring quads in a row share their vertical edge.
    a_row_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && (o_cell_index != 4'd2) &&
         (o_cell_index != 4'd5) && (o_cell_index != 4'd8)) |=>
        ((o_dst_x0 == $past(o_dst_x1)) && (o_tex_u0 == $past(o_tex_u1)) &&
         (o_dst_y0 == $past(o_dst_y0)) && (o_tex_v0 == $past(o_tex_v0))))
        else $error("adjacent quads in a row do not share an edge");
`endif

endmodule

[test/nsq_quad_checker.sv]
module nsq_quad_checker #(
    parameter int FRAC_BITS = nsq_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [nsq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nsq_pkg::CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [nsq_pkg::POS_W-1:0]       i_rect_left,
    input  logic [nsq_pkg::POS_W-1:0]       i_rect_top,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_rect_width,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_rect_height,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_out_width,
    input  logic [nsq_pkg::SIZE_W-1:0]      i_out_height,

    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  nsq_pkg::t_quad                  i_quad,

    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_quads_checked
);
    import nsq_pkg::*;

    localparam longint TEX_HI = (64'sd1 <<< (TEX_W - 1)) - 64'sd1;
    localparam longint TEX_LO = -(64'sd1 <<< (TEX_W - 1));
    localparam int     REPORT_LIMIT = 10;

    logic [INSET_W-1:0] inset_left_q;
    logic [INSET_W-1:0] inset_right_q;
    logic [INSET_W-1:0] inset_top_q;
    logic [INSET_W-1:0] inset_bottom_q;
    logic [ATLAS_W-1:0] atlas_width_q;
    logic [ATLAS_W-1:0] atlas_height_q;

    t_quad expected_quads[$];
    int    mismatches = 0;
    int    quads_checked = 0;
    int    pending = 0;

    assign o_mismatches    = mismatches;
    assign o_pending       = pending;
    assign o_quads_checked = quads_checked;

    // Atlas fraction of a texel position, truncated toward zero and saturated.
    function automatic t_tex tex_coord(input longint texel, input logic [ATLAS_W-1:0] size);
        longint divisor;
        longint quotient;
        divisor  = (size == '0) ? 64'sd1 : longint'(size);
        quotient = (texel * (64'sd1 <<< FRAC_BITS)) / divisor;
        if (quotient > TEX_HI) quotient = TEX_HI;
        if (quotient < TEX_LO) quotient = TEX_LO;
        return t_tex'(quotient);
    endfunction

    function automatic void queue_request_quads(
        input logic [POS_W-1:0]  rl,
        input logic [POS_W-1:0]  rt,
        input logic [SIZE_W-1:0] rw,
        input logic [SIZE_W-1:0] rh,
        input logic [SIZE_W-1:0] ow,
        input logic [SIZE_W-1:0] oh
    );
        longint dst_x[4];
        longint dst_y[4];
        longint src_x[4];
        longint src_y[4];
        t_quad  quad;
        int     cell_num;
        dst_x[0] = 0;
        dst_x[1] = longint'(inset_left_q);
        dst_x[2] = longint'(ow) - longint'(inset_right_q);
        dst_x[3] = longint'(ow);
        dst_y[0] = 0;
        dst_y[1] = longint'(inset_top_q);
        dst_y[2] = longint'(oh) - longint'(inset_bottom_q);
        dst_y[3] = longint'(oh);
        src_x[0] = 0;
        src_x[1] = longint'(inset_left_q);
        src_x[2] = longint'(rw) - longint'(inset_right_q);
        src_x[3] = longint'(rw);
        src_y[0] = 0;
        src_y[1] = longint'(inset_top_q);
        src_y[2] = longint'(rh) - longint'(inset_bottom_q);
        src_y[3] = longint'(rh);
        cell_num = 0;
        for (int gy = 0; gy < GRID; gy++) begin
            for (int gx = 0; gx < GRID; gx++) begin
                quad.cell_index = CELL_W'(cell_num);
                quad.last       = (cell_num == NUM_CELLS - 1);
                quad.dst_x0     = t_dst'(dst_x[gx]);
                quad.dst_y0     = t_dst'(dst_y[gy]);
                quad.dst_x1     = t_dst'(dst_x[gx + 1]);
                quad.dst_y1     = t_dst'(dst_y[gy + 1]);
                quad.tex_u0     = tex_coord(longint'(rl) + src_x[gx], atlas_width_q);
                quad.tex_v0     = tex_coord(longint'(rt) + src_y[gy], atlas_height_q);
                quad.tex_u1     = tex_coord(longint'(rl) + src_x[gx + 1], atlas_width_q);
                quad.tex_v1     = tex_coord(longint'(rt) + src_y[gy + 1], atlas_height_q);
                expected_quads.push_back(quad);
                cell_num++;
            end
        end
    endfunction

    function automatic void show_quad(input string tag, input t_quad q);
        $display("  %s: cell=%0d last=%0b dst=(%0d,%0d)-(%0d,%0d) tex=(%0d,%0d)-(%0d,%0d)",
                 tag, q.cell_index, q.last, q.dst_x0, q.dst_y0, q.dst_x1, q.dst_y1,
                 q.tex_u0, q.tex_v0, q.tex_u1, q.tex_v1);
    endfunction

    always @(posedge i_clk) begin
        t_quad expected;
        if (!i_rst_n) begin
            inset_left_q   = '0;
            inset_right_q  = '0;
            inset_top_q    = '0;
            inset_bottom_q = '0;
            atlas_width_q  = ATLAS_W'(1);
            atlas_height_q = ATLAS_W'(1);
            expected_quads.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_quads.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("quad with no request behind it");
                        show_quad("actual  ", i_quad);
                    end
                    mismatches++;
                end else begin
                    expected = expected_quads.pop_front();
                    quads_checked++;
                    if (i_quad !== expected) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("quad mismatch");
                            show_quad("expected", expected);
                            show_quad("actual  ", i_quad);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                queue_request_quads(i_rect_left, i_rect_top, i_rect_width, i_rect_height,
                                    i_out_width, i_out_height);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INSET_LEFT:   inset_left_q   = i_cfg_data[INSET_W-1:0];
                    REG_INSET_RIGHT:  inset_right_q  = i_cfg_data[INSET_W-1:0];
                    REG_INSET_TOP:    inset_top_q    = i_cfg_data[INSET_W-1:0];
                    REG_INSET_BOTTOM: inset_bottom_q = i_cfg_data[INSET_W-1:0];
                    REG_ATLAS_WIDTH:  atlas_width_q  = i_cfg_data[ATLAS_W-1:0];
                    REG_ATLAS_HEIGHT: atlas_height_q = i_cfg_data[ATLAS_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = expected_quads.size();
    end

endmodule

[test/testbench.sv]
module testbench;
    import nsq_pkg::*;

    // Run shape. The cycle limit is several times the slowest legal run: every
    // quad held up by the longest receiver gap and every request by the
    // longest sender gap, plus the long hold-off and pipeline latency.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int NUM_PHASES    = 6;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int BURST_ITEMS   = 40;
    localparam int PRESSURE_PHASE = 3;

    // Indexes with no register behind them; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [SIZE_W-1:0] out_w;
        logic [SIZE_W-1:0] out_h;
    } t_draw_req;

    // Every input of the block starts at a known value.
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [POS_W-1:0]      rect_left   = '0;
    logic [POS_W-1:0]      rect_top    = '0;
    logic [SIZE_W-1:0]     rect_width  = '0;
    logic [SIZE_W-1:0]     rect_height = '0;
    logic [SIZE_W-1:0]     out_width   = '0;
    logic [SIZE_W-1:0]     out_height  = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [CELL_W-1:0]     cell_index;
    logic                  last;
    t_dst                  dst_x0, dst_y0, dst_x1, dst_y1;
    t_tex                  tex_u0, tex_v0, tex_u1, tex_v1;
    t_quad                 seen_quad;

    int mismatches;
    int pending;
    int quads_checked;

    // Flags shared between the stimulus and the receiver process.
    bit steady      = 1'b0;
    int holds_asked = 0;
    int holds_done  = 0;

    int requests_sent = 0;
    int cycle_count   = 0;

    assign seen_quad = {cell_index, last, dst_x0, dst_y0, dst_x1, dst_y1,
                        tex_u0, tex_v0, tex_u1, tex_v1};

    nine_slice_quad_generator_unit DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_rect_left   (rect_left),
        .i_rect_top    (rect_top),
        .i_rect_width  (rect_width),
        .i_rect_height (rect_height),
        .i_out_width   (out_width),
        .i_out_height  (out_height),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_cell_index  (cell_index),
        .o_last        (last),
        .o_dst_x0      (dst_x0),
        .o_dst_y0      (dst_y0),
        .o_dst_x1      (dst_x1),
        .o_dst_y1      (dst_y1),
        .o_tex_u0      (tex_u0),
        .o_tex_v0      (tex_v0),
        .o_tex_u1      (tex_u1),
        .o_tex_v1      (tex_v1)
    );

    // The checker watches both channels and the register port on its own.
    nsq_quad_checker #(
        .FRAC_BITS (FRAC_BITS_DEF)
    ) quad_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_rect_left     (rect_left),
        .i_rect_top      (rect_top),
        .i_rect_width    (rect_width),
        .i_rect_height   (rect_height),
        .i_out_width     (out_width),
        .i_out_height    (out_height),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_quad          (seen_quad),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_quads_checked (quads_checked)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Gap lengths: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        else if (roll < 92) return $urandom_range(1, 3);
        else if (roll < 98) return $urandom_range(4, 12);
        else return $urandom_range(20, 45);
    endfunction

    // Receiver: idles at random, and on request holds off for a long stretch,
    // counted here, so that the block backs up into its input.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (steady) begin
                out_ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    function automatic t_draw_req make_req(
        input logic [POS_W-1:0]  l,
        input logic [POS_W-1:0]  t,
        input logic [SIZE_W-1:0] w,
        input logic [SIZE_W-1:0] h,
        input logic [SIZE_W-1:0] ow,
        input logic [SIZE_W-1:0] oh
    );
        t_draw_req req;
        req.left   = l;
        req.top    = t;
        req.width  = w;
        req.height = h;
        req.out_w  = ow;
        req.out_h  = oh;
        return req;
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        else if (roll == 1) return {POS_W{1'b1}};
        else return POS_W'($urandom_range(0, 4095));
    endfunction

    // Sizes lean towards the legal range, with the odd raw 13-bit value so
    // that the top bit is exercised beyond 4096 as well.
    function automatic logic [SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return '0;
        else if (roll == 1) return SIZE_W'(4096);
        else if (roll == 2) return SIZE_W'($urandom_range(0, 8191));
        else if (roll < 6) return SIZE_W'($urandom_range(0, 64));
        else return SIZE_W'($urandom_range(0, 4096));
    endfunction

    function automatic t_draw_req random_request();
        return make_req(pick_pos(), pick_pos(), pick_size(), pick_size(),
                        pick_size(), pick_size());
    endfunction

    // One register write, made while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_setting(
        input logic [CFG_DATA_W-1:0] l,
        input logic [CFG_DATA_W-1:0] r,
        input logic [CFG_DATA_W-1:0] t,
        input logic [CFG_DATA_W-1:0] b,
        input logic [CFG_DATA_W-1:0] aw,
        input logic [CFG_DATA_W-1:0] ah
    );
        write_reg(REG_INSET_LEFT, l);
        write_reg(REG_INSET_RIGHT, r);
        write_reg(REG_INSET_TOP, t);
        write_reg(REG_INSET_BOTTOM, b);
        write_reg(REG_ATLAS_WIDTH, aw);
        write_reg(REG_ATLAS_HEIGHT, ah);
    endtask

    // Offers one item after a gap and returns at the edge that accepts it.
    // Valid is left high so that a following item with no gap goes back to back.
    task automatic offer_request(input t_draw_req req, input int gap);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        rect_left   <= req.left;
        rect_top    <= req.top;
        rect_width  <= req.width;
        rect_height <= req.height;
        out_width   <= req.out_w;
        out_height  <= req.out_h;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    // The sender stops and waits until every expected quad has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Register settings for the random phases: zero insets with the largest
    // atlas, saturating insets with a zero atlas width, inset writes with the
    // top data bit set (which must be masked off), the pressure phase with
    // writes to the spare indexes, fully random raw values, and odd divisors.
    task automatic apply_phase_setting(input int phase);
        case (phase)
            0: write_setting(0, 0, 0, 0, 4096, 4096);
            1: write_setting(4095, 4095, 4095, 4095, 0, 1);
            2: write_setting(13'h1000 | CFG_DATA_W'($urandom_range(0, 31)),
                             13'h1000 | CFG_DATA_W'($urandom_range(0, 31)),
                             13'h1FFF, 13'h1000, 8191, 4095);
            3: begin
                write_setting(CFG_DATA_W'($urandom_range(0, 64)),
                              CFG_DATA_W'($urandom_range(0, 64)),
                              CFG_DATA_W'($urandom_range(0, 64)),
                              CFG_DATA_W'($urandom_range(0, 64)),
                              CFG_DATA_W'($urandom_range(1, 4096)),
                              CFG_DATA_W'($urandom_range(1, 4096)));
                write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 8191)));
                write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 8191)));
            end
            4: write_setting(CFG_DATA_W'($urandom_range(0, 8191)),
                             CFG_DATA_W'($urandom_range(0, 8191)),
                             CFG_DATA_W'($urandom_range(0, 8191)),
                             CFG_DATA_W'($urandom_range(0, 8191)),
                             CFG_DATA_W'($urandom_range(0, 8191)),
                             CFG_DATA_W'($urandom_range(0, 8191)));
            default: write_setting(CFG_DATA_W'($urandom_range(1, 8)),
                                   CFG_DATA_W'($urandom_range(1, 8)),
                                   CFG_DATA_W'($urandom_range(1, 8)),
                                   CFG_DATA_W'($urandom_range(1, 8)), 3, 7);
        endcase
    endtask

    initial begin : stimulus
        int gap;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: no insets and an atlas of one texel, so texture
        // coordinates of four texels or more saturate at the top.
        offer_request(make_req(0, 0, 0, 0, 0, 0), pick_gap());
        offer_request(make_req(4095, 4095, 4096, 4096, 4096, 4096), pick_gap());
        offer_request(make_req(1, 2, 8191, 8191, 8191, 8191), pick_gap());
        drain();

        // Moderate insets with divisors that are not powers of two, so that
        // truncation toward zero shows on both signs.
        write_setting(8, 8, 6, 6, 300, 200);
        offer_request(make_req(0, 0, 0, 0, 0, 0), pick_gap());
        offer_request(make_req(100, 50, 64, 32, 200, 100), pick_gap());
        offer_request(make_req(4095, 4095, 4096, 4096, 4096, 4096), pick_gap());
        offer_request(make_req(4095, 4095, 8191, 8191, 8191, 8191), pick_gap());
        // Source narrower than its insets: a negative source breakpoint.
        offer_request(make_req(0, 0, 3, 2, 50, 40), pick_gap());
        // Destination narrower than its insets: a negative corner.
        offer_request(make_req(10, 10, 40, 40, 5, 4), pick_gap());
        // Sizes equal to the inset sums: the middle cells collapse.
        offer_request(make_req(7, 9, 16, 12, 16, 12), pick_gap());
        offer_request(make_req(3, 3, 1, 1, 1, 1), pick_gap());
        offer_request(make_req(4095, 0, 0, 0, 4096, 0), pick_gap());
        offer_request(make_req(0, 4095, 4096, 1, 0, 4096), pick_gap());
        offer_request(make_req(12'hAAA, 12'h555, 13'h1555, 13'h0AAA, 13'h0AAA, 13'h1555),
                      pick_gap());
        offer_request(make_req(12'h555, 12'hAAA, 13'h0AAA, 13'h1555, 13'h1555, 13'h0AAA),
                      pick_gap());

        // Random phases, each behind a full drain and a fresh register setting.
        // The first runs with no idling at all on either side. In the pressure
        // phase the receiver stops for a long stretch while the sender keeps
        // offering items back to back.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            apply_phase_setting(phase);
            steady = (phase == 0);
            if (phase == PRESSURE_PHASE) holds_asked++;
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
                if (steady || (phase == PRESSURE_PHASE && n < BURST_ITEMS)) gap = 0;
                else gap = pick_gap();
                offer_request(random_request(), gap);
            end
        end
        steady = 1'b0;

        // Let everything come out, then leave room for any stray quad.
        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d draw requests over %0d register settings, %0d quads compared,",
                 requests_sent, NUM_PHASES + 2, quads_checked);
        $display("with random gaps on both sides, a steady stretch and a long output hold-off.");
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/nsq_pkg.sv
sv/nsq_queue.sv
sv/nsq_front.sv
sv/nsq_divider.sv
sv/nsq_back.sv
sv/nine_slice_quad_generator_unit.sv
test/nsq_quad_checker.sv
test/testbench.sv
